// ----- design/qalu_pkg.sv -----
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared opcodes, component types and saturation helper for the quaternion ALU.
// ----------------------------------------------------------------------------
package qalu_pkg;

  // opcodes
  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_INV  = 3'd3;
  localparam logic [2:0] OP_ROT  = 3'd4;
  localparam logic [2:0] OP_DOT  = 3'd5;
  localparam logic [2:0] OP_NORM = 3'd6;

  localparam int unsigned EPS_W      = 17;
  localparam logic [EPS_W-1:0] EPS_RESET = 17'd66;
  localparam int unsigned SQRT_STEPS = 32;  // one root bit per stage
  localparam int unsigned QUO_BITS   = 32;  // one quotient bit per stage

  // index 0..3 = x, y, z, w
  typedef logic [3:0][31:0] quat_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- design/quaternion_alu.sv -----
// ----------------------------------------------------------------------------
// quaternion_alu
// Fixed-point quaternion arithmetic unit: product, normalized sum,
// difference, conjugate and normalize, vector rotation and dot product.
// ----------------------------------------------------------------------------
// Throughput is one beat per clock on each side; every opcode takes the same
// path, so results leave in input order (five front stages of multiply
// and add, 32 square-root stages of one root bit each, 33 divider stages
// (prep, then one quotient bit per stage) and the output register). The
// input stalls only when the output register and its skid register are both
// full; valid bits ride with the data, so bubbles cost nothing. The epsilon
// register (reset 66, Q16.16) should only be written while the unit is idle.
// Components are two's complement with FracBits fraction bits; results
// saturate to 32 bits, and a normalization whose magnitude is zero or below
// epsilon returns the identity (0,0,0,1) with degenerate_o set.
// ----------------------------------------------------------------------------
module quaternion_alu import qalu_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [EPS_W-1:0]   cfg_wdata_i,
  // input beats
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] az_i,
  input  logic signed [31:0] aw_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] bz_i,
  input  logic signed [31:0] bw_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rx_o,
  output logic signed [31:0] ry_o,
  output logic signed [31:0] rz_o,
  output logic signed [31:0] rw_o,
  output logic               degenerate_o
);

  // side data carried alongside the root and divide pipes
  typedef struct packed {
    logic [2:0] op;
    quat_t      res;
    quat_t      c;
    logic       big;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] op;
    quat_t      res;
  } dv_side_t;

  typedef struct packed {
    quat_t r;
    logic  deg;
  } beat_t;

  // epsilon register
  logic [EPS_W-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= EPS_RESET;
    else if (cfg_we_i) eps_q <= cfg_wdata_i;
  end

  // whole pipe advances unless the skid register holds a beat
  logic en;
  logic skid_v_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  quat_t a_in, b_in;
  assign a_in = {aw_i, az_i, ay_i, ax_i};
  assign b_in = {bw_i, bz_i, by_i, bx_i};

  // front end
  logic        fe_valid;
  logic [2:0]  fe_op;
  quat_t       fe_res, fe_c;
  logic [64:0] fe_sumsq;

  qalu_front #(
    .FracBits (FracBits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i && !in_stall_o),
    .op_i    (opcode_i),
    .a_i     (a_in),
    .b_i     (b_in),
    .valid_o (fe_valid),
    .op_o    (fe_op),
    .res_o   (fe_res),
    .c_o     (fe_c),
    .sumsq_o (fe_sumsq)
  );

  // square root of the sum of squares; only four -2^31 components reach 2^64
  sq_side_t sq_in, sq_out;
  logic     sq_valid;
  logic [31:0] sq_root;

  assign sq_in = '{op: fe_op, res: fe_res, c: fe_c, big: fe_sumsq[64]};

  qalu_sqrt #(
    .SideW ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .rad_i   (fe_sumsq[63:0]),
    .side_i  (sq_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_out)
  );

  // divide each component by the magnitude
  dv_side_t dv_in, dv_out;
  logic     dv_valid, dv_deg;
  quat_t    dv_q;

  assign dv_in = '{op: sq_out.op, res: sq_out.res};

  qalu_div #(
    .FracBits (FracBits),
    .SideW    ($bits(dv_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .c_i     (sq_out.c),
    .big_i   (sq_out.big),
    .root_i  (sq_root),
    .eps_i   (eps_q),
    .side_i  (dv_in),
    .valid_o (dv_valid),
    .q_o     (dv_q),
    .deg_o   (dv_deg),
    .side_o  (dv_out)
  );

  // pick normalized or direct result
  beat_t fin;

  always_comb begin
    fin.r   = dv_out.res;
    fin.deg = 1'b0;
    if (dv_out.op inside {OP_ADD, OP_SUB, OP_INV, OP_NORM}) begin
      fin.r   = dv_q;
      fin.deg = dv_deg;
    end
  end

  // output register with skid register
  logic  out_v_q;
  beat_t out_q, skid_q;
  logic  push, pop;

  assign push = en && dv_valid;
  assign pop  = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (push) begin
      if (out_v_q && !pop) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_v_q && !pop) skid_q <= fin;
      else out_q <= fin;
    end
  end

  assign out_valid_o  = out_v_q;
  assign rx_o         = out_q.r[0];
  assign ry_o         = out_q.r[1];
  assign rz_o         = out_q.r[2];
  assign rw_o         = out_q.r[3];
  assign degenerate_o = out_q.deg;

endmodule

// ----- design/qalu_front.sv -----
// ----------------------------------------------------------------------------
// qalu_front
// Five-stage front end: operand prep, products, sums, rotation matrix
// products and sum of squares for normalization.
// ----------------------------------------------------------------------------
module qalu_front import qalu_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [2:0]  op_i,
  input  quat_t       a_i,
  input  quat_t       b_i,
  output logic        valid_o,
  output logic [2:0]  op_o,
  output quat_t       res_o,
  output quat_t       c_o,
  output logic [64:0] sumsq_o
);

  localparam logic signed [63:0] Half = 64'sd1 <<< (FracBits - 1);
  localparam logic signed [63:0] One  = 64'sd1 <<< FracBits;
  localparam int RotI [9] = '{0, 1, 2, 0, 0, 1, 3, 3, 3};
  localparam int RotJ [9] = '{0, 1, 2, 1, 2, 2, 0, 1, 2};

  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    return (p + Half) >>> FracBits;
  endfunction

  // ---- stage A: input register
  logic              va_q;
  logic [2:0]        opa_q;
  logic signed [31:0] aa_q [4];
  logic signed [31:0] ba_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en_i) va_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opa_q <= op_i;
      for (int i = 0; i < 4; i++) begin
        aa_q[i] <= a_i[i];
        ba_q[i] <= b_i[i];
      end
    end
  end

  // ---- stage B: normalization operand, rounded products
  logic signed [31:0] cb_d   [4];
  logic signed [63:0] pab_d  [4][4];
  logic signed [63:0] paa_d  [9];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (opa_q)
        OP_ADD:  cb_d[i] = sat32(66'(aa_q[i]) + 66'(ba_q[i]));
        OP_SUB:  cb_d[i] = sat32(66'(aa_q[i]) - 66'(ba_q[i]));
        OP_INV: begin
          if (i < 3) cb_d[i] = sat32(-66'(aa_q[i]));
          else       cb_d[i] = aa_q[i];
        end
        default: cb_d[i] = aa_q[i];
      endcase
      for (int j = 0; j < 4; j++) begin
        pab_d[i][j] = rnd(64'(aa_q[i]) * 64'(ba_q[j]));
      end
    end
    for (int k = 0; k < 9; k++) begin
      paa_d[k] = rnd(64'(aa_q[RotI[k]]) * 64'(aa_q[RotJ[k]])) <<< 1;
    end
  end

  logic               vb_q;
  logic [2:0]         opb_q;
  logic signed [31:0] bb_q  [3];
  logic signed [31:0] cb_q  [4];
  logic signed [63:0] pab_q [4][4];
  logic signed [63:0] paa_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en_i) vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opb_q <= opa_q;
      pab_q <= pab_d;
      paa_q <= paa_d;
      cb_q  <= cb_d;
      for (int i = 0; i < 3; i++) bb_q[i] <= ba_q[i];
    end
  end

  // ---- stage C: product sums, rotation matrix, squares
  logic signed [63:0] sx, sy, sz, sw, sdot;
  logic [31:0]        resc_d [4];
  logic signed [31:0] m_d    [9];
  logic [31:0]        mc     [4];
  logic [63:0]        sq_d   [4];

  always_comb begin
    sx   = pab_q[3][0] + pab_q[0][3] + pab_q[1][2] - pab_q[2][1];
    sy   = pab_q[3][1] - pab_q[0][2] + pab_q[1][3] + pab_q[2][0];
    sz   = pab_q[3][2] + pab_q[0][1] - pab_q[1][0] + pab_q[2][3];
    sw   = pab_q[3][3] - pab_q[0][0] - pab_q[1][1] - pab_q[2][2];
    sdot = pab_q[0][0] + pab_q[1][1] + pab_q[2][2] + pab_q[3][3];
    for (int i = 0; i < 4; i++) resc_d[i] = '0;
    case (opb_q)
      OP_MUL: begin
        resc_d[0] = sat32(sx);
        resc_d[1] = sat32(sy);
        resc_d[2] = sat32(sz);
        resc_d[3] = sat32(sw);
      end
      OP_DOT:  resc_d[0] = sat32(sdot);
      default: ;
    endcase
    // paa: xx yy zz xy xz yz wx wy wz
    m_d[0] = sat32(One - (paa_q[1] + paa_q[2]));
    m_d[1] = sat32(paa_q[3] - paa_q[8]);
    m_d[2] = sat32(paa_q[4] + paa_q[7]);
    m_d[3] = sat32(paa_q[3] + paa_q[8]);
    m_d[4] = sat32(One - (paa_q[0] + paa_q[2]));
    m_d[5] = sat32(paa_q[5] - paa_q[6]);
    m_d[6] = sat32(paa_q[4] - paa_q[7]);
    m_d[7] = sat32(paa_q[5] + paa_q[6]);
    m_d[8] = sat32(One - (paa_q[0] + paa_q[1]));
    for (int i = 0; i < 4; i++) begin
      mc[i]   = cb_q[i][31] ? (~cb_q[i] + 32'd1) : cb_q[i];
      sq_d[i] = 64'(mc[i]) * 64'(mc[i]);
    end
  end

  logic               vc_q;
  logic [2:0]         opc_q;
  logic signed [31:0] bc_q   [3];
  logic signed [31:0] cc_q   [4];
  logic [31:0]        resc_q [4];
  logic signed [31:0] m_q    [9];
  logic [63:0]        sqc_q  [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en_i) vc_q <= vb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opc_q  <= opb_q;
      bc_q   <= bb_q;
      cc_q   <= cb_q;
      resc_q <= resc_d;
      m_q    <= m_d;
      sqc_q  <= sq_d;
    end
  end

  // ---- stage D: matrix times vector products, sum of squares
  logic signed [63:0] pm_d [9];
  logic [64:0]        sum_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pm_d[3*i+j] = rnd(64'(m_q[3*i+j]) * 64'(bc_q[j]));
      end
    end
    sum_d = 65'(sqc_q[0]) + 65'(sqc_q[1]) + 65'(sqc_q[2]) + 65'(sqc_q[3]);
  end

  logic               vd_q;
  logic [2:0]         opd_q;
  logic signed [31:0] cd_q   [4];
  logic [31:0]        resd_q [4];
  logic signed [63:0] pm_q   [9];
  logic [64:0]        sumd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else if (en_i) vd_q <= vc_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opd_q  <= opc_q;
      cd_q   <= cc_q;
      resd_q <= resc_q;
      pm_q   <= pm_d;
      sumd_q <= sum_d;
    end
  end

  // ---- stage E: rotated vector, result select
  logic [31:0] rese_d [4];

  always_comb begin
    if (opd_q == OP_ROT) begin
      for (int i = 0; i < 3; i++) begin
        rese_d[i] = sat32(pm_q[3*i] + pm_q[3*i+1] + pm_q[3*i+2]);
      end
      rese_d[3] = '0;
    end else begin
      rese_d = resd_q;
    end
  end

  logic               ve_q;
  logic [2:0]         ope_q;
  logic signed [31:0] ce_q   [4];
  logic [31:0]        rese_q [4];
  logic [64:0]        sume_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else if (en_i) ve_q <= vd_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ope_q  <= opd_q;
      ce_q   <= cd_q;
      rese_q <= rese_d;
      sume_q <= sumd_q;
    end
  end

  assign valid_o = ve_q;
  assign op_o    = ope_q;
  assign sumsq_o = sume_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res_o[i] = rese_q[i];
      c_o[i]   = ce_q[i];
    end
  end

endmodule

// ----- design/qalu_sqrt.sv -----
// ----------------------------------------------------------------------------
// qalu_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qalu_sqrt import qalu_pkg::*; #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [63:0]      rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      root_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned Steps = SQRT_STEPS;

  logic             v_q    [Steps];
  logic [63:0]      r_q    [Steps];
  logic [63:0]      x_q    [Steps-1];
  logic [SideW-1:0] side_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic             v_in;
    logic [63:0]      x_in, r_in, trial, x_d, r_d;
    logic [SideW-1:0] s_in;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = rad_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
      assign s_in = side_q[k-1];
    end

    always_comb begin
      trial = r_in + Bit;
      if (x_in >= trial) begin
        x_d = x_in - trial;
        r_d = (r_in >> 1) + Bit;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k] <= 1'b0;
      else if (en_i) v_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= r_d;
        side_q[k] <= s_in;
      end
    end

    if (k < Steps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) x_q[k] <= x_d;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign root_o  = r_q[Steps-1][31:0];
  assign side_o  = side_q[Steps-1];

endmodule

// ----- design/qalu_div.sv -----
// ----------------------------------------------------------------------------
// qalu_div
// Four-lane pipelined restoring divider for normalization, one quotient
// bit per stage, with epsilon test, rounding and saturation.
// ----------------------------------------------------------------------------
module qalu_div import qalu_pkg::*; #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned SideW    = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  quat_t            c_i,
  input  logic             big_i,
  input  logic [31:0]      root_i,
  input  logic [EPS_W-1:0] eps_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output quat_t            q_o,
  output logic             deg_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned NumW  = 33 + FracBits;
  localparam int unsigned Steps = QUO_BITS;
  localparam logic [31:0] One32 = 32'd1 << FracBits;

  // ---- prep stage: magnitude, degenerate test, rounded numerators
  logic [32:0]      mag;
  logic             deg;
  logic [31:0]      ac     [4];
  logic [NumW-1:0]  num    [4];
  logic [3:0]       ovf;

  always_comb begin
    mag = big_i ? {1'b1, 32'd0} : {1'b0, root_i};
    deg = (mag == '0) || (mag < 33'(eps_i));
    for (int i = 0; i < 4; i++) begin
      ac[i]  = c_i[i][31] ? (~c_i[i] + 32'd1) : c_i[i];
      num[i] = NumW'({ac[i], {FracBits{1'b0}}}) + NumW'(mag >> 1);
      ovf[i] = 33'(num[i][NumW-1:32]) >= mag;
    end
  end

  logic             pv_q;
  logic [SideW-1:0] pside_q;
  logic             pdeg_q;
  logic [32:0]      pmag_q;
  logic [3:0]       pneg_q, povf_q;
  logic [3:0][32:0] prem_q;
  logic [3:0][31:0] plo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else if (en_i) pv_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pside_q <= side_i;
      pdeg_q  <= deg;
      pmag_q  <= mag;
      povf_q  <= ovf;
      for (int i = 0; i < 4; i++) begin
        pneg_q[i] <= c_i[i][31];
        prem_q[i] <= 33'(num[i][NumW-1:32]);
        plo_q[i]  <= num[i][31:0];
      end
    end
  end

  // ---- quotient stages
  logic             v_q    [Steps];
  logic [SideW-1:0] side_q [Steps];
  logic             deg_q  [Steps];
  logic [32:0]      mag_q  [Steps];
  logic [3:0]       neg_q  [Steps];
  logic [3:0]       ovf_q  [Steps];
  logic [3:0][31:0] quo_q  [Steps];
  logic [3:0][32:0] rem_q  [Steps-1];
  logic [3:0][31:0] lo_q   [Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic             v_in, deg_in;
    logic [SideW-1:0] s_in;
    logic [32:0]      mag_in;
    logic [3:0]       neg_in, ovf_in;
    logic [3:0][31:0] quo_in, lo_in, quo_d, lo_d;
    logic [3:0][32:0] rem_in, rem_d;
    logic [33:0]      rem_ext [4];
    logic [3:0]       ge;

    if (k == 0) begin : g_first
      assign v_in   = pv_q;
      assign s_in   = pside_q;
      assign deg_in = pdeg_q;
      assign mag_in = pmag_q;
      assign neg_in = pneg_q;
      assign ovf_in = povf_q;
      assign quo_in = '0;
      assign rem_in = prem_q;
      assign lo_in  = plo_q;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign s_in   = side_q[k-1];
      assign deg_in = deg_q[k-1];
      assign mag_in = mag_q[k-1];
      assign neg_in = neg_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rem_ext[i] = {rem_in[i], lo_in[i][31]};
        ge[i]      = rem_ext[i] >= {1'b0, mag_in};
        rem_d[i]   = ge[i] ? 33'(rem_ext[i] - {1'b0, mag_in}) : rem_ext[i][32:0];
        lo_d[i]    = lo_in[i] << 1;
        quo_d[i]   = {quo_in[i][30:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k] <= 1'b0;
      else if (en_i) v_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
        deg_q[k]  <= deg_in;
        mag_q[k]  <= mag_in;
        neg_q[k]  <= neg_in;
        ovf_q[k]  <= ovf_in;
        quo_q[k]  <= quo_d;
      end
    end

    if (k < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          lo_q[k]  <= lo_d;
        end
      end
    end
  end

  // ---- sign and saturation on the last stage
  logic [31:0] qf;
  logic        big;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qf  = quo_q[Steps-1][i];
      big = qf[31] && (qf[30:0] != '0);
      if (deg_q[Steps-1]) begin
        q_o[i] = (i == 3) ? One32 : 32'd0;
      end else if (neg_q[Steps-1][i]) begin
        q_o[i] = (ovf_q[Steps-1][i] || big) ? 32'h8000_0000 : (~qf + 32'd1);
      end else begin
        q_o[i] = (ovf_q[Steps-1][i] || qf[31]) ? 32'h7fff_ffff : qf;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign deg_o   = deg_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule
